/* hw/rtl/lsd_pkg.sv */
// shared types and constants of the lifo stack with default
package lsd_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    FN_PUSH       = 3'd0,
    FN_PUSH_NODUP = 3'd1,
    FN_POP        = 3'd2,
    FN_PEEK       = 3'd3,
    FN_READ_AT    = 3'd4,
    FN_TRUNCATE   = 3'd5
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
  } lsd_cmd_t;

  typedef struct packed {
    logic out_stall;
  } lsd_stat_t;

endpackage

/* hw/rtl/lsd_ctrl.sv */
// controller state machine: takes a beat, then runs it through the datapath
module lsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lsd_pkg::lsd_stat_t stat,
  output lsd_pkg::lsd_cmd_t  cmd
);
  import lsd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_stall) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/lsd_dp.sv */
// datapath: entry store, count, default register and output register
module lsd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lsd_pkg::lsd_cmd_t                 cmd,
  output lsd_pkg::lsd_stat_t                stat,
  input  logic [2:0]                        in_func,
  input  logic [lsd_pkg::DATA_WIDTH-1:0]    in_value,
  input  logic [3:0]                        in_pos,
  input  logic [4:0]                        in_keep,
  input  logic                              cfg_we,
  input  logic [lsd_pkg::DATA_WIDTH-1:0]    cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lsd_pkg::DATA_WIDTH-1:0]    out_data,
  output logic                              out_dvalid,
  output logic [1:0]                        out_status,
  output logic [lsd_pkg::CNT_W-1:0]         out_depth
);
  import lsd_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [DATA_WIDTH-1:0] default_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  func_t                 func_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [3:0]            pos_r;
  logic [4:0]            keep_r;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [ADDR_W-1:0]     rd_addr;

  logic                  oval_r;
  logic [DATA_WIDTH-1:0] odata_r, odata_nxt;
  logic                  odv_r, odv_nxt;
  logic [1:0]            ost_r, ost_nxt;

  logic                  empty, full, wr_en;
  logic [DATA_WIDTH-1:0] top;

  always_comb begin
    if (func_t'(in_func) == FN_READ_AT) begin
      rd_addr = in_pos[ADDR_W-1:0];
    end else begin
      rd_addr = ADDR_W'(count_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= mem[rd_addr];
      func_r    <= func_t'(in_func);
      val_r     <= in_value;
      pos_r     <= in_pos;
      keep_r    <= in_keep;
    end
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= val_r;
    end
  end

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign top   = empty ? default_r : rd_data_r;

  always_comb begin
    count_nxt = count_r;
    odata_nxt = '0;
    odv_nxt   = 1'b0;
    ost_nxt   = ST_OK;
    wr_en     = 1'b0;
    case (func_r)
      FN_PUSH: begin
        if (full) begin
          ost_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.exec;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_PUSH_NODUP: begin
        if (val_r == top) begin
          ost_nxt = ST_DUP;
        end else if (full) begin
          ost_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.exec;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_POP: begin
        odv_nxt   = 1'b1;
        odata_nxt = top;
        if (empty) begin
          ost_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FN_PEEK: begin
        odv_nxt   = 1'b1;
        odata_nxt = top;
        if (empty) begin
          ost_nxt = ST_EMPTY;
        end
      end
      FN_READ_AT: begin
        if (CNT_W'(pos_r) < count_r) begin
          odv_nxt   = 1'b1;
          odata_nxt = rd_data_r;
        end else begin
          ost_nxt = ST_EMPTY;
        end
      end
      FN_TRUNCATE: begin
        if (CNT_W'(keep_r) < count_r) begin
          count_nxt = CNT_W'(keep_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= '0;
      count_r   <= '0;
      oval_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        count_r <= count_nxt;
        oval_r  <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      odata_r <= odata_nxt;
      odv_r   <= odv_nxt;
      ost_r   <= ost_nxt;
    end
  end

  assign stat.out_stall = oval_r & ~out_ready;
  assign out_valid      = oval_r;
  assign out_data       = odata_r;
  assign out_dvalid     = odv_r;
  assign out_status     = ost_r;
  assign out_depth      = count_r;

endmodule

/* hw/rtl/lifo_stack_with_default.sv */
// top level of the lifo stack with default value
//
// A 16-entry stack of 32-bit words. Each input beat carries one operation in
// in_tuser (push, push unless equal to top, pop, peek, read at position,
// truncate) and its operands in in_tdata. Every input beat gives exactly one
// output beat with the read word, its valid flag, a status code and the
// entry count after the operation.
// Pop and peek on an empty stack return the default word from cfg_wdata, written
// with cfg_we; the user must write it while the block is idle, which it does not enforce.
// Timing: an item is taken in the idle state, where the store is read into a
// register, and the result is loaded into the output register in the execute
// state once the output is not stalled. The block takes no new item until the
// last one has executed; the registered read of the entry store sets this.
// A result waiting in the output register does not block the next input
// beat; that beat is held before execution until the output is taken.
// Reset (rst_n low, synchronous) empties the stack, clears the default word
// and drops out_tvalid; the entry contents are left as they are.
module lifo_stack_with_default (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsd_pkg::DATA_WIDTH-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // push_value[31:0], read_position[35:32], keep_count[40:36], zero fill
  input  logic [lsd_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[2:0]
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_data[31:0], status[33:32], depth_now[38:34], zero fill
  output logic [lsd_pkg::OUT_DATA_W-1:0]  out_tdata,
  // data_valid[0]
  output logic                            out_tuser
);
  import lsd_pkg::*;

  lsd_cmd_t              cmd;
  lsd_stat_t             stat;
  logic [DATA_WIDTH-1:0] rdata;
  logic [1:0]            status;
  logic [CNT_W-1:0]      depth;

  lsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_tuser),
    .in_value   (in_tdata[31:0]),
    .in_pos     (in_tdata[35:32]),
    .in_keep    (in_tdata[40:36]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (rdata),
    .out_dvalid (out_tuser),
    .out_status (status),
    .out_depth  (depth)
  );

  assign out_tdata = {1'b0, depth, status, rdata};

endmodule
